[hw/rtl/assert_macros.svh]
// Assertion macros for the port-level checker; they expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/cta_pkg.sv]
// Package with widths, opcodes, stage records and helpers of the checked integer ALU.
package cta_pkg;

    localparam int DATA_W     = 64;
    localparam int OPC_W      = 5;
    localparam int WB_W       = 4;
    localparam int BITS_W     = 7;
    localparam int HALF_W     = DATA_W / 2;
    localparam int VALUE_BITS = 64;
    localparam int DIV_STAGES = DATA_W;

    typedef enum logic [OPC_W-1:0] {
        OPC_ADD   = 5'd0,
        OPC_SUB   = 5'd1,
        OPC_MUL   = 5'd2,
        OPC_DIV   = 5'd3,
        OPC_MOD   = 5'd4,
        OPC_AND   = 5'd5,
        OPC_XOR   = 5'd6,
        OPC_OR    = 5'd7,
        OPC_EQ    = 5'd8,
        OPC_NE    = 5'd9,
        OPC_LT    = 5'd10,
        OPC_LE    = 5'd11,
        OPC_GT    = 5'd12,
        OPC_GE    = 5'd13,
        OPC_SHL   = 5'd14,
        OPC_SHR   = 5'd15,
        OPC_NEG   = 5'd16,
        OPC_COMMA = 5'd17
    } t_opcode;

    // Record that travels with every beat down the whole pipe.
    typedef struct packed {
        logic              mul_sel;
        logic              div_sel;
        logic              div_mod;
        logic              q_neg;
        logic              r_neg;
        logic              ok;
        logic [DATA_W-1:0] res;
    } t_side;

    // Multiplier operands: magnitudes for signed, masked values for unsigned.
    // The limit is the overflow bound when checked, else the type mask.
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] lim;
        logic              chk;
        logic              neg;
    } t_mul_op;

    typedef struct packed {
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] d;
    } t_div_op;

    function automatic logic [DATA_W-1:0] low_mask(input logic [BITS_W-1:0] n);
        if (n >= BITS_W'(DATA_W)) begin
            return '1;
        end
        return (DATA_W'(1) << n) - DATA_W'(1);
    endfunction

endpackage

[hw/rtl/cta_req_if.sv]
// Request channel interface: opcode, operands, type width and signedness.
interface cta_req_if;
    logic                           valid;
    logic                           ready;
    logic [cta_pkg::OPC_W-1:0]      opcode;
    logic signed [cta_pkg::DATA_W-1:0] operand_a;
    logic signed [cta_pkg::DATA_W-1:0] operand_b;
    logic [cta_pkg::WB_W-1:0]       width_bytes;
    logic                           is_unsigned;

    modport source (output valid, opcode, operand_a, operand_b, width_bytes, is_unsigned,
                    input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, width_bytes, is_unsigned,
                    output ready);
endinterface

[hw/rtl/cta_res_if.sv]
// Result channel interface: folded value and ok flag.
interface cta_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [cta_pkg::DATA_W-1:0] result_value;
    logic                              ok;

    modport source (output valid, result_value, ok, input ready);
    modport sink   (input valid, result_value, ok, output ready);
endinterface

[hw/rtl/cta_prep.sv]
// Decode stage: type width, operand conditioning, simple operations and shifts.
module cta_prep (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [cta_pkg::OPC_W-1:0]      i_opcode,
    input  logic signed [cta_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [cta_pkg::DATA_W-1:0] i_operand_b,
    input  logic [cta_pkg::WB_W-1:0]       i_width_bytes,
    input  logic                           i_is_unsigned,
    output logic                           o_vld,
    output cta_pkg::t_side                 o_side,
    output cta_pkg::t_mul_op               o_mul,
    output cta_pkg::t_div_op               o_div
);
    import cta_pkg::*;

    localparam int EXT = DATA_W - VALUE_BITS;

    logic [WB_W-1:0]          bytes_sat;
    logic [BITS_W-1:0]        bits;
    logic [DATA_W-1:0]        mask, ua, ub, smax, smin, sign_bit, sat, shl_max;
    logic signed [DATA_W-1:0] sa, sb;
    logic signed [DATA_W:0]   sum, diff, lo_bound, hi_bound;
    logic [DATA_W-1:0]        mag_a, mag_b;
    logic                     cnt_ok, uns;
    logic [5:0]               cnt;
    t_side                    n_side;
    t_mul_op                  n_mul;
    t_div_op                  n_div;

    logic                     r_vld;
    t_side                    r_side;
    t_mul_op                  r_mul;
    t_div_op                  r_div;

    always_comb begin
        uns       = i_is_unsigned;
        bytes_sat = (i_width_bytes > WB_W'(8)) ? WB_W'(8) : i_width_bytes;
        bits      = {bytes_sat, 3'b000};
        if (bits > BITS_W'(VALUE_BITS)) begin
            bits = BITS_W'(VALUE_BITS);
        end
        mask = low_mask(bits);
        ua   = i_operand_a & mask;
        ub   = i_operand_b & mask;
        sa   = (i_operand_a <<< EXT) >>> EXT;
        sb   = (i_operand_b <<< EXT) >>> EXT;
        smax = low_mask(BITS_W'(VALUE_BITS - 1));
        smin = ~smax;
        hi_bound = $signed({1'b0, smax});
        lo_bound = $signed({1'b1, smin});
        sum   = $signed({sa[DATA_W-1], sa}) + $signed({sb[DATA_W-1], sb});
        diff  = $signed({sa[DATA_W-1], sa}) - $signed({sb[DATA_W-1], sb});
        mag_a = sa[DATA_W-1] ? DATA_W'(-sa) : DATA_W'(sa);
        mag_b = sb[DATA_W-1] ? DATA_W'(-sb) : DATA_W'(sb);

        // Shift count must be non-negative and below the type width.
        cnt_ok   = !i_operand_b[DATA_W-1] && (i_operand_b < DATA_W'(bits));
        cnt      = i_operand_b[5:0];
        sign_bit = DATA_W'(1) << (bits - BITS_W'(1));
        sat      = (bits >= BITS_W'(DATA_W)) ? i_operand_a
                                             : ((i_operand_a & mask) ^ sign_bit) - sign_bit;
        shl_max  = low_mask(bits - BITS_W'(1)) >> cnt;

        n_mul.a   = uns ? ua : mag_a;
        n_mul.b   = uns ? ub : mag_b;
        n_mul.chk = !uns;
        n_mul.neg = !uns && (sa[DATA_W-1] ^ sb[DATA_W-1]);
        n_mul.lim = uns ? mask : (n_mul.neg ? smax + DATA_W'(1) : smax);
        n_div.n   = uns ? ua : mag_a;
        n_div.d   = uns ? ub : mag_b;

        n_side = '0;
        case (t_opcode'(i_opcode))
            OPC_ADD: begin
                n_side.ok  = uns || !(sum > hi_bound || sum < lo_bound);
                n_side.res = uns ? (ua + ub) & mask : sum[DATA_W-1:0];
            end
            OPC_SUB: begin
                n_side.ok  = uns || !(diff > hi_bound || diff < lo_bound);
                n_side.res = uns ? (ua - ub) & mask : diff[DATA_W-1:0];
            end
            OPC_MUL: begin
                n_side.ok      = 1'b1;
                n_side.mul_sel = 1'b1;
            end
            OPC_DIV, OPC_MOD: begin
                n_side.ok = (n_div.d != '0) &&
                            !(!uns && (sa == $signed(smin)) && (sb == '1));
                n_side.div_sel = n_side.ok;
                n_side.div_mod = (t_opcode'(i_opcode) == OPC_MOD);
                n_side.q_neg   = !uns && (sa[DATA_W-1] ^ sb[DATA_W-1]);
                n_side.r_neg   = !uns && sa[DATA_W-1];
            end
            OPC_AND: begin
                n_side.ok  = 1'b1;
                n_side.res = uns ? ua & ub : sa & sb;
            end
            OPC_XOR: begin
                n_side.ok  = 1'b1;
                n_side.res = uns ? ua ^ ub : sa ^ sb;
            end
            OPC_OR: begin
                n_side.ok  = 1'b1;
                n_side.res = uns ? ua | ub : sa | sb;
            end
            OPC_EQ: begin
                n_side.ok  = 1'b1;
                n_side.res = DATA_W'(uns ? ua == ub : sa == sb);
            end
            OPC_NE: begin
                n_side.ok  = 1'b1;
                n_side.res = DATA_W'(uns ? ua != ub : sa != sb);
            end
            OPC_LT: begin
                n_side.ok  = 1'b1;
                n_side.res = DATA_W'(uns ? ua < ub : sa < sb);
            end
            OPC_LE: begin
                n_side.ok  = 1'b1;
                n_side.res = DATA_W'(uns ? ua <= ub : sa <= sb);
            end
            OPC_GT: begin
                n_side.ok  = 1'b1;
                n_side.res = DATA_W'(uns ? ua > ub : sa > sb);
            end
            OPC_GE: begin
                n_side.ok  = 1'b1;
                n_side.res = DATA_W'(uns ? ua >= ub : sa >= sb);
            end
            OPC_SHL: begin
                if (uns) begin
                    n_side.ok  = cnt_ok;
                    n_side.res = (ua << cnt) & mask;
                end else begin
                    n_side.ok  = cnt_ok && !sat[DATA_W-1] && (sat <= shl_max);
                    n_side.res = sat << cnt;
                end
            end
            OPC_SHR: begin
                n_side.ok  = cnt_ok;
                n_side.res = uns ? ua >> cnt : DATA_W'($signed(sat) >>> cnt);
            end
            OPC_NEG: begin
                n_side.ok  = uns || (sa != $signed(smin));
                n_side.res = uns ? (DATA_W'(0) - ua) & mask : DATA_W'(0) - sa;
            end
            default: begin
                n_side.ok = 1'b0;
            end
        endcase

        // Unsigned results are cut to the type width, comparison flags included.
        if (uns) begin
            n_side.res = n_side.res & mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_mul  <= n_mul;
            r_div  <= n_div;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_mul  = r_mul;
    assign o_div  = r_div;
endmodule

[hw/rtl/cta_mul.sv]
// Two-stage 64x64 multiplier: 32-bit partial products, then sum and overflow check.
module cta_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  cta_pkg::t_side   i_side,
    input  cta_pkg::t_mul_op i_mul,
    input  cta_pkg::t_div_op i_div,
    output logic             o_vld,
    output cta_pkg::t_side   o_side,
    output cta_pkg::t_div_op o_div
);
    import cta_pkg::*;

    logic                r_vld1, r_vld2;
    logic [DATA_W-1:0]   r_pp0, r_pp1, r_pp2, r_pp3, r_lim;
    logic                r_chk, r_neg;
    t_side               r_side1, r_side2;
    t_div_op             r_div1, r_div2;

    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   hi, lo;
    t_side               n_side;

    always_comb begin
        prod = {r_pp3, r_pp0}
             + ((2*DATA_W)'(r_pp1) << HALF_W)
             + ((2*DATA_W)'(r_pp2) << HALF_W);
        hi = prod[2*DATA_W-1:DATA_W];
        lo = prod[DATA_W-1:0];
        n_side = r_side1;
        if (r_side1.mul_sel) begin
            if (r_chk) begin
                n_side.ok  = (hi == '0) && (lo <= r_lim);
                n_side.res = r_neg ? DATA_W'(0) - lo : lo;
            end else begin
                n_side.res = lo & r_lim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp0   <= i_mul.a[HALF_W-1:0] * i_mul.b[HALF_W-1:0];
            r_pp1   <= i_mul.a[HALF_W-1:0] * i_mul.b[DATA_W-1:HALF_W];
            r_pp2   <= i_mul.a[DATA_W-1:HALF_W] * i_mul.b[HALF_W-1:0];
            r_pp3   <= i_mul.a[DATA_W-1:HALF_W] * i_mul.b[DATA_W-1:HALF_W];
            r_lim   <= i_mul.lim;
            r_chk   <= i_mul.chk;
            r_neg   <= i_mul.neg;
            r_side1 <= i_side;
            r_div1  <= i_div;
            r_side2 <= n_side;
            r_div2  <= r_div1;
        end
    end

    assign o_vld  = r_vld2;
    assign o_side = r_side2;
    assign o_div  = r_div2;
endmodule

[hw/rtl/cta_div.sv]
// Restoring divider, one quotient bit per pipeline stage.
module cta_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  cta_pkg::t_side             i_side,
    input  cta_pkg::t_div_op           i_div,
    output logic                       o_vld,
    output cta_pkg::t_side             o_side,
    output logic [cta_pkg::DATA_W-1:0] o_quo,
    output logic [cta_pkg::DATA_W-1:0] o_rem
);
    import cta_pkg::*;

    logic [DATA_W-1:0] w_rem  [DIV_STAGES+1];
    logic [DATA_W-1:0] w_nq   [DIV_STAGES+1];
    logic [DATA_W-1:0] w_d    [DIV_STAGES+1];
    t_side             w_side [DIV_STAGES+1];
    logic              w_vld  [DIV_STAGES+1];

    assign w_rem[0]  = '0;
    assign w_nq[0]   = i_div.n;
    assign w_d[0]    = i_div.d;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_vld;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DATA_W:0]   trial;
        logic              ge;
        logic [DATA_W-1:0] n_rem;
        logic [DATA_W-1:0] r_rem, r_nq, r_d;
        t_side             r_side;
        logic              r_vld;

        always_comb begin
            trial = {w_rem[k], w_nq[k][DATA_W-1]};
            ge    = trial >= {1'b0, w_d[k]};
            n_rem = ge ? DATA_W'(trial - {1'b0, w_d[k]}) : trial[DATA_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_nq   <= {w_nq[k][DATA_W-2:0], ge};
                r_d    <= w_d[k];
                r_side <= w_side[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_nq[k+1]   = r_nq;
        assign w_d[k+1]    = r_d;
        assign w_side[k+1] = r_side;
        assign w_vld[k+1]  = r_vld;
    end

    assign o_vld  = w_vld[DIV_STAGES];
    assign o_side = w_side[DIV_STAGES];
    assign o_quo  = w_nq[DIV_STAGES];
    assign o_rem  = w_rem[DIV_STAGES];
endmodule

[hw/rtl/checked_typed_integer_alu.sv]
// Top level of the checked typed integer ALU: pipeline assembly and output register.
//
//   channel | dir | payload                                               | handshake
//   i_req   | in  | opcode, operand_a, operand_b, width_bytes, is_unsigned | valid/ready
//   o_res   | out | result_value, ok                                      | valid/ready
//
// One beat is accepted per cycle when the output can move; every beat passes 68 register
// stages: one decode stage, two multiplier stages, the 64 stages of the one-bit-per-stage
// divider, and the output stage.
// Reset is synchronous and active low; it clears the valid bit of every stage.
// A stalled output freezes the whole pipe in place, so no beat is dropped or repeated.
module checked_typed_integer_alu (
    input  logic i_clk,
    input  logic i_rst_n,
    cta_req_if.sink   i_req,
    cta_res_if.source o_res
);
    import cta_pkg::*;

    // The whole pipe advances together whenever the output register is free or drains.
    logic    en;
    logic    prep_vld, mul_vld, div_vld;
    t_side   prep_side, mul_side, div_side;
    t_mul_op prep_mul;
    t_div_op prep_div, mul_div;
    logic [DATA_W-1:0] div_quo, div_rem, fin_res;

    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_res;
    logic              r_out_ok;

    assign en          = !r_out_vld || o_res.ready;
    assign i_req.ready = en;

    cta_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (i_req.valid),
        .i_opcode      (i_req.opcode),
        .i_operand_a   (i_req.operand_a),
        .i_operand_b   (i_req.operand_b),
        .i_width_bytes (i_req.width_bytes),
        .i_is_unsigned (i_req.is_unsigned),
        .o_vld         (prep_vld),
        .o_side        (prep_side),
        .o_mul         (prep_mul),
        .o_div         (prep_div)
    );

    cta_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (prep_vld),
        .i_side  (prep_side),
        .i_mul   (prep_mul),
        .i_div   (prep_div),
        .o_vld   (mul_vld),
        .o_side  (mul_side),
        .o_div   (mul_div)
    );

    cta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (mul_vld),
        .i_side  (mul_side),
        .i_div   (mul_div),
        .o_vld   (div_vld),
        .o_side  (div_side),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Division works on magnitudes; the quotient takes the sign of the operand product
    // and the remainder the sign of the dividend, as in truncating division.
    always_comb begin
        fin_res = div_side.res;
        if (div_side.div_sel) begin
            if (div_side.div_mod) begin
                fin_res = div_side.r_neg ? DATA_W'(0) - div_rem : div_rem;
            end else begin
                fin_res = div_side.q_neg ? DATA_W'(0) - div_quo : div_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
    end

    // A failed fold always reports a zero value.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res <= div_side.ok ? fin_res : '0;
            r_out_ok  <= div_side.ok;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.result_value = r_out_res;
    assign o_res.ok           = r_out_ok;
endmodule

[hw/rtl/cta_chk.sv]
// Port-level checker of the checked typed integer ALU and its bind statement.
`include "assert_macros.svh"

module cta_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cta_pkg::DATA_W-1:0] i_out_value,
    input logic                       i_out_ok
);
    import cta_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_value))
    `ASSERT_SAME(a_fail_zero, i_out_valid && !i_out_ok, i_out_value == '0)
    `ASSERT_SAME(a_stall_back, i_out_valid && !i_out_ready, !i_in_ready)
endmodule

bind checked_typed_integer_alu cta_chk u_cta_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_value (o_res.result_value),
    .i_out_ok    (o_res.ok)
);

[verif/cta_tb_if.sv]
// Testbench-side copies of nothing: interfaces come from the RTL; this file holds the beat records.
package cta_tb_pkg;
    import cta_pkg::*;

    // One request beat as the stimulus side builds it.
    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [WB_W-1:0]   width_bytes;
        logic              is_unsigned;
    } t_req_beat;

    // One expected result beat.
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              ok;
    } t_fold;
endpackage

[verif/cta_checker.sv]
// Checker that watches both channels, folds each request and compares the results.
module cta_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cta_req_if.sink      i_req_mon,
    cta_res_if.sink      i_res_mon,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cta_pkg::*;
    import cta_tb_pkg::*;

    t_fold expected_folds[$];

    function automatic logic [63:0] type_mask(input int nbits);
        if (nbits >= 64) begin
            return '1;
        end
        return (64'd1 << nbits) - 64'd1;
    endfunction

    function automatic logic [63:0] sign_extend(input logic [63:0] v, input int nbits);
        logic [63:0] m;
        if (nbits >= 64) begin
            return v;
        end
        m = 64'd1 << (nbits - 1);
        return ((v & type_mask(nbits)) ^ m) - m;
    endfunction

    // Folds one request beat into the expected value and ok flag.
    function automatic t_fold fold_request(input t_req_beat rq);
        t_fold f;
        int nbits;
        logic [63:0] msk, ua, ub, r, ma, mb, lim;
        logic signed [63:0] sa, sb;
        logic [127:0] prod;
        logic neg;
        t_opcode op;
        op = t_opcode'(rq.opcode);
        nbits = (rq.width_bytes > 8 ? 8 : rq.width_bytes) * 8;
        msk = type_mask(nbits);
        ua = rq.operand_a;
        ub = rq.operand_b;
        sa = ua;
        sb = ub;
        f.ok = 1'b1;
        r = '0;
        if (op == OPC_SHL || op == OPC_SHR) begin
            if (sb < 0 || sb >= nbits) begin
                f.ok = 1'b0;
            end else if (rq.is_unsigned) begin
                r = ((op == OPC_SHL) ? ((ua & msk) << ub[5:0]) : ((ua & msk) >> ub[5:0])) & msk;
            end else begin
                r = sign_extend(ua, nbits);
                if (op == OPC_SHR) begin
                    r = $signed(r) >>> ub[5:0];
                end else if (r[63] || r > (type_mask(nbits - 1) >> ub[5:0])) begin
                    f.ok = 1'b0;
                end else begin
                    r = r << ub[5:0];
                end
            end
        end else if (rq.is_unsigned) begin
            ua &= msk;
            ub &= msk;
            case (op)
                OPC_ADD: r = ua + ub;
                OPC_SUB: r = ua - ub;
                OPC_MUL: r = ua * ub;
                OPC_DIV: if (ub == 0) f.ok = 1'b0; else r = ua / ub;
                OPC_MOD: if (ub == 0) f.ok = 1'b0; else r = ua % ub;
                OPC_AND: r = ua & ub;
                OPC_XOR: r = ua ^ ub;
                OPC_OR:  r = ua | ub;
                OPC_EQ:  r = 64'(ua == ub);
                OPC_NE:  r = 64'(ua != ub);
                OPC_LT:  r = 64'(ua < ub);
                OPC_LE:  r = 64'(ua <= ub);
                OPC_GT:  r = 64'(ua > ub);
                OPC_GE:  r = 64'(ua >= ub);
                OPC_NEG: r = 64'd0 - ua;
                default: f.ok = 1'b0;
            endcase
            r &= msk;
        end else begin
            case (op)
                OPC_ADD: begin
                    r = ua + ub;
                    f.ok = !(ua[63] == ub[63] && r[63] != ua[63]);
                end
                OPC_SUB: begin
                    r = ua - ub;
                    f.ok = !(ua[63] != ub[63] && r[63] != ua[63]);
                end
                OPC_MUL: begin
                    // Magnitude product against the bound that depends on the sign.
                    ma = sa < 0 ? 64'd0 - ua : ua;
                    mb = sb < 0 ? 64'd0 - ub : ub;
                    neg = (sa < 0) != (sb < 0);
                    prod = ma * mb;
                    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    if (prod[127:64] != 0 || prod[63:0] > lim) begin
                        f.ok = 1'b0;
                    end else begin
                        r = neg ? 64'd0 - prod[63:0] : prod[63:0];
                    end
                end
                OPC_DIV, OPC_MOD: begin
                    // Zero divisor and minimum over minus one both refuse to fold.
                    if (sb == 0 || (ua == 64'h8000_0000_0000_0000 && sb == -1)) begin
                        f.ok = 1'b0;
                    end else begin
                        r = (op == OPC_DIV) ? sa / sb : sa % sb;
                    end
                end
                OPC_AND: r = ua & ub;
                OPC_XOR: r = ua ^ ub;
                OPC_OR:  r = ua | ub;
                OPC_EQ:  r = 64'(sa == sb);
                OPC_NE:  r = 64'(sa != sb);
                OPC_LT:  r = 64'(sa < sb);
                OPC_LE:  r = 64'(sa <= sb);
                OPC_GT:  r = 64'(sa > sb);
                OPC_GE:  r = 64'(sa >= sb);
                OPC_NEG: begin
                    if (ua == 64'h8000_0000_0000_0000) f.ok = 1'b0;
                    else r = 64'd0 - ua;
                end
                default: f.ok = 1'b0;
            endcase
        end
        f.result_value = f.ok ? r : '0;
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_req_beat rq;
        t_fold want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_req_mon.valid && i_req_mon.ready) begin
                rq = {i_req_mon.opcode, i_req_mon.operand_a, i_req_mon.operand_b,
                      i_req_mon.width_bytes, i_req_mon.is_unsigned};
                expected_folds.push_back(fold_request(rq));
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (expected_folds.size() == 0) begin
                    $error("result beat with no request waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_folds.pop_front();
                    if (want.result_value !== i_res_mon.result_value) begin
                        $error("result_value expected %h actual %h",
                               want.result_value, i_res_mon.result_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (want.ok !== i_res_mon.ok) begin
                        $error("ok expected %b actual %b", want.ok, i_res_mon.ok);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_folds.size();
    end
endmodule

[verif/tb.sv]
// Testbench top: clock, reset, request stimulus, result back-pressure and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cta_pkg::*;
    import cta_tb_pkg::*;

    localparam int RANDOM_BEATS = 1750;
    // The pipe is 68 deep; the limit covers every beat stalled at random several times over.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   calm = 1'b0;

    cta_req_if req_ch();
    cta_res_if res_ch();

    checked_typed_integer_alu i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    cta_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch.sink),
        .i_res_mon    (res_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // The consumer holds off on about 8 percent of cycles, except in the calm stretch.
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(99) >= 8);
    end

    // The run ends in failure if the cycle count reaches its limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("checked_typed_integer_alu verification failed");
            $finish;
        end
    end

    t_req_beat directed[$];

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return {$urandom, $urandom};
            3: return 64'($signed($urandom_range(20)) - 10);
            4: return {{56{1'($urandom_range(1))}}, 8'($urandom)};
            default: return {32'($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0), $urandom};
        endcase
    endfunction

    function automatic t_req_beat random_beat();
        t_req_beat b;
        b.opcode = ($urandom_range(30) == 0) ? 5'($urandom) : 5'($urandom_range(OPC_COMMA));
        b.operand_a = pick_operand();
        b.operand_b = pick_operand();
        // Shift counts mostly in range so shifts get past the count check.
        if ((b.opcode == OPC_SHL || b.opcode == OPC_SHR) && $urandom_range(3) != 0) begin
            b.operand_b = 64'($urandom_range(63));
        end
        b.width_bytes = ($urandom_range(9) == 0) ? 4'($urandom) :
                        4'(1 << $urandom_range(3));
        b.is_unsigned = 1'($urandom);
        return b;
    endfunction

    // Sends one beat, idling first at random, and holds it until the handshake.
    task automatic send_beat(input t_req_beat b);
        while (!calm && $urandom_range(99) < 8) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= b.opcode;
        req_ch.operand_a   <= b.operand_a;
        req_ch.operand_b   <= b.operand_b;
        req_ch.width_bytes <= b.width_bytes;
        req_ch.is_unsigned <= b.is_unsigned;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int n;
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        req_ch.width_bytes = 4'd8;
        req_ch.is_unsigned = 1'b0;

        // Directed beats: overflow edges, division corners, shift limits, negation of
        // the minimum, comma, an unused opcode and a zero type width.
        directed.push_back({OPC_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 4'd8, 1'b0});
        directed.push_back({OPC_SUB, 64'h8000_0000_0000_0000, 64'd1, 4'd8, 1'b0});
        directed.push_back({OPC_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                            4'd8, 1'b0});
        directed.push_back({OPC_MUL, 64'h8000_0000_0000_0000, 64'd1, 4'd8, 1'b0});
        directed.push_back({OPC_MUL, 64'h1_0000_0000, 64'h8000_0000, 4'd8, 1'b0});
        directed.push_back({OPC_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                            4'd2, 1'b1});
        directed.push_back({OPC_DIV, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                            4'd8, 1'b0});
        directed.push_back({OPC_MOD, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                            4'd8, 1'b0});
        directed.push_back({OPC_DIV, 64'd7, 64'd0, 4'd4, 1'b0});
        directed.push_back({OPC_MOD, 64'd7, 64'h100, 4'd1, 1'b1});
        directed.push_back({OPC_MOD, -64'sd7, 64'd2, 4'd8, 1'b0});
        directed.push_back({OPC_AND, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0F0F, 4'd1, 1'b1});
        directed.push_back({OPC_XOR, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5, 4'd8, 1'b0});
        directed.push_back({OPC_OR, 64'h80, 64'h1, 4'd2, 1'b1});
        directed.push_back({OPC_EQ, 64'h100, 64'h0, 4'd1, 1'b1});
        directed.push_back({OPC_NE, 64'h1, 64'h1, 4'd8, 1'b0});
        directed.push_back({OPC_LT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 4'd8, 1'b0});
        directed.push_back({OPC_LE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 4'd4, 1'b1});
        directed.push_back({OPC_GT, 64'd1, 64'd1, 4'd8, 1'b0});
        directed.push_back({OPC_GE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0});
        directed.push_back({OPC_SHL, 64'h40, 64'd1, 4'd1, 1'b0});
        directed.push_back({OPC_SHL, 64'h1, 64'd63, 4'd8, 1'b1});
        directed.push_back({OPC_SHR, 64'h80, 64'd7, 4'd1, 1'b0});
        directed.push_back({OPC_SHR, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1});
        directed.push_back({OPC_SHL, 64'h1, 64'd0, 4'd0, 1'b1});
        directed.push_back({OPC_EQ, 64'd3, 64'd5, 4'd0, 1'b1});
        directed.push_back({OPC_NEG, 64'h8000_0000_0000_0000, 64'd0, 4'd8, 1'b0});
        directed.push_back({OPC_COMMA, 64'd1, 64'd2, 4'd15, 1'b1});
        directed.push_back({5'd31, 64'd1, 64'd2, 4'd8, 1'b0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_beat(directed[k]);
        end
        for (n = 0; n < RANDOM_BEATS; n++) begin
            // A stretch in the middle runs without any idling on either side.
            calm = (n >= 700 && n < 1000);
            send_beat(random_beat());
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("checked_typed_integer_alu verification clean");
        end else begin
            $display("checked_typed_integer_alu verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/cta_pkg.sv
hw/rtl/cta_req_if.sv
hw/rtl/cta_res_if.sv
hw/rtl/cta_prep.sv
hw/rtl/cta_mul.sv
hw/rtl/cta_div.sv
hw/rtl/checked_typed_integer_alu.sv
hw/rtl/cta_chk.sv
verif/cta_tb_if.sv
verif/cta_checker.sv
verif/tb.sv
